@@ rtl/occ_pkg.sv @@
// package for the ones-complement checksum core
// types, register indexes and the end-around carry helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

  localparam int unsigned AccW   = 32;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ResW   = 17;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // register index as seen in paddr[2]
  localparam logic RegResultMode = 1'b0;

  localparam logic [WordW-1:0] NoChecksum = 16'hffff;

  typedef enum logic [1:0] {
    MODE_INET    = 2'd0,
    MODE_PARTIAL = 2'd1,
    MODE_FOLD    = 2'd2
  } occ_mode_e;

  // finished packet handed to the result stages
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [AccW-1:0] seed;
  } occ_fin_t;

  // 32-bit add with end-around carry
  function automatic logic [AccW-1:0] add_eac(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW-1:0] + {{(AccW-1){1'b0}}, s[AccW]};
  endfunction

  // fold 32 bits to 16 with one end-around step
  function automatic logic [WordW-1:0] fold16(input logic [AccW-1:0] x);
    logic [WordW:0] a;
    a = {1'b0, x[AccW-1:WordW]} + {1'b0, x[WordW-1:0]};
    a = a + {{WordW{1'b0}}, a[WordW]};
    return a[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ones_complement_checksum_core.sv @@
// path: a packet's sum is registered in fin_q, then in t_q/fa_q/sc_q, then in res_q
// throughput: one byte per cycle; the byte accumulator never stalls on its own,
// the input stalls only once three results queue behind a stalled output
// reset: mode 0, accumulator, seed, held byte and phase cleared, no result pending
// top level of the ones-complement checksum core; uses occ_pkg and occ_finish
`timescale 1ns / 1ps
`default_nettype none

module ones_complement_checksum_core import occ_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0]      prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic              first_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic [AccW-1:0]   seed_sum_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ResW-1:0]        checksum_value_o
);

  logic [1:0]        mode_q;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   seed_q, seed_d;
  logic [ByteW-1:0]  held_q, held_d;
  logic              phase_q, phase_d;
  logic              v1_q;
  occ_fin_t          fin_q;
  logic              fin_stall;
  logic              en1;
  logic              accept;
  logic              cfg_we;

  logic              eff_phase;
  logic [AccW-1:0]   eff_acc;
  logic [WordW-1:0]  word;
  logic [AccW-1:0]   sum;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegResultMode);
  assign prdata = (paddr[2] == RegResultMode) ? {{(PdataW-2){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= MODE_INET;
    else if (cfg_we) mode_q <= pwdata[1:0];
  end

  assign en1        = !v1_q || !fin_stall;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  // byte pairing; a trailing odd byte is padded so exactly one add per byte at most
  always_comb begin
    eff_phase = first_byte_i ? 1'b0 : phase_q;
    eff_acc   = first_byte_i ? '0 : acc_q;
    seed_d    = first_byte_i ? seed_sum_i : seed_q;
    word      = eff_phase ? {held_q, data_byte_i} : {data_byte_i, 8'h00};
    sum       = add_eac(eff_acc, {{(AccW-WordW){1'b0}}, word});
    if (last_byte_i) begin
      acc_d   = '0;
      phase_d = 1'b0;
      held_d  = '0;
    end else begin
      acc_d   = eff_phase ? sum : eff_acc;
      phase_d = !eff_phase;
      held_d  = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      seed_q  <= '0;
      held_q  <= '0;
      phase_q <= 1'b0;
      v1_q    <= 1'b0;
    end else begin
      if (accept) begin
        acc_q   <= acc_d;
        seed_q  <= seed_d;
        held_q  <= held_d;
        phase_q <= phase_d;
      end
      if (en1) v1_q <= accept && last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      fin_q.acc  <= (eff_phase || last_byte_i) ? sum : eff_acc;
      fin_q.seed <= seed_d;
    end
  end

  occ_finish u_occ_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .fin_valid_i      (v1_q),
    .fin_i            (fin_q),
    .fin_stall_o      (fin_stall),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .checksum_value_o (checksum_value_o)
  );

endmodule

`default_nettype wire

@@ rtl/occ_finish.sv @@
// result stages of the checksum core: partial folds, then mode selection
// into the output register; uses occ_pkg
`timescale 1ns / 1ps
`default_nettype none

module occ_finish import occ_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [1:0]      mode_i,
  input  wire logic            fin_valid_i,
  input  wire occ_fin_t        fin_i,
  output logic                 fin_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [ResW-1:0]      checksum_value_o
);

  logic              v2_q;
  logic [AccW-1:0]   t_q;
  logic [WordW-1:0]  fa_q;
  logic [WordW:0]    sc_q;
  logic              vo_q;
  logic [ResW-1:0]   res_q;
  logic [ResW-1:0]   res_d;
  logic              en_out;
  logic              en2;

  logic [WordW+1:0]  c;
  logic [WordW:0]    c2;
  logic [WordW:0]    f;
  logic [WordW:0]    f2;

  assign en_out      = !vo_q || !out_stall_i;
  assign en2         = !v2_q || en_out;
  assign fin_stall_o = !en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en2) v2_q <= fin_valid_i;
      if (en_out) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && fin_valid_i) begin
      t_q  <= add_eac(fin_i.acc, {{(AccW-WordW){1'b0}}, fin_i.seed[WordW-1:0]});
      fa_q <= fold16(fin_i.acc);
      sc_q <= {1'b0, fin_i.seed[AccW-1:WordW]} + {1'b0, fin_i.seed[WordW-1:0]};
    end
    if (en_out && v2_q) res_q <= res_d;
  end

  always_comb begin
    c  = {1'b0, sc_q} + {2'b00, fa_q};
    c2 = {15'd0, c[WordW+1:WordW]} + {1'b0, c[WordW-1:0]};
    f  = {16'd0, c2[WordW]} + {1'b0, c2[WordW-1:0]};
    f2 = f + {16'd0, f[WordW]};
    unique case (mode_i)
      MODE_PARTIAL: res_d = c2;
      MODE_FOLD: begin
        if (f2 == {1'b0, NoChecksum}) res_d = {1'b0, NoChecksum};
        else                          res_d = {1'b0, ~f2[WordW-1:0]};
      end
      default: res_d = {1'b0, ~fold16(t_q)};
    endcase
  end

  assign out_valid_o      = vo_q;
  assign checksum_value_o = res_q;

endmodule

`default_nettype wire

@@ rtl/occ_checker.sv @@
// port-level checks for the checksum core, bound to the top level
// uses occ_pkg for the register index
`timescale 1ns / 1ps
`default_nettype none

module occ_checker import occ_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] prdata,
  input  wire logic              pready,
  input  wire logic              in_stall_o,
  input  wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic [ResW-1:0]   checksum_value_o
);

  // input only backs up when the output is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(checksum_value_o)))
    else $error("held result changed");

  // only the partial sum mode can set bit 16
  a_bit16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !psel && (paddr[2] == RegResultMode)
     && (prdata[1:0] != MODE_PARTIAL)) |-> (checksum_value_o[WordW] == 1'b0))
    else $error("bit 16 set outside partial sum mode");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("config transaction not ready");

endmodule

bind ones_complement_checksum_core occ_checker u_occ_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .psel             (psel),
  .paddr            (paddr),
  .prdata           (prdata),
  .pready           (pready),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .checksum_value_o (checksum_value_o)
);

`default_nettype wire
